/* hdl/pcgds_pkg.sv */
// Types and constants for the particle cull and depth sort block.
// Used by particle_cull_group_depth_sort; depends on nothing.
package pcgds_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned DirW   = 16;
  localparam int unsigned DepthW = 40;
  localparam int unsigned AccW   = 43;
  localparam int unsigned KeyW   = 72;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegDirX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDirY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDirZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPosX  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPosY  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPosZ  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLayer = 3'd6;

  localparam logic signed [AccW-1:0] DepthMax = 43'sd549755813887;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [23:0] pw;
    logic [31:0]        rgba;
    logic [15:0]        radius;
    logic [15:0]        fade;
    logic [15:0]        layer;
    logic [15:0]        tex_start;
    logic [15:0]        tex_end;
    logic               final_req;
  } pcgds_in_t;

  typedef struct packed {
    logic signed [23:0] out_px;
    logic signed [23:0] out_py;
    logic signed [23:0] out_pz;
    logic signed [23:0] out_pw;
    logic [31:0]        out_rgba;
    logic [15:0]        out_radius;
    logic [15:0]        out_fade;
    logic [15:0]        out_tex_start;
    logic [15:0]        out_tex_end;
    logic signed [39:0] depth;
    logic               overflow;
    logic               is_last;
  } pcgds_out_t;

  // stored entry: result fields without the two flags
  localparam int unsigned EntryW = $bits(pcgds_out_t) - 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_STORE = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FETCH = 6'b010000,
    S_EMIT  = 6'b100000
  } pcgds_state_e;

endpackage

/* hdl/particle_cull_group_depth_sort.sv */
// Particle view-depth cull, texture grouping and depth sort, top level.
// Depends on pcgds_pkg.
//
//   channel  signals                                   direction
//   in       in_valid_i / in_ready_o / in_data_i       particle in
//   out      out_valid_o / out_ready_i / out_data_o    sorted particle out
//   cfg      cfg_valid_i / cfg_ready_o / cfg_idx_i,    register write
//            cfg_data_i
//
// Each particle makes three passes through the one 25x16 multiplier (S_MUL),
// then its depth is summed, culled and stored (S_STORE). After a final item
// every result takes a selection scan over all kept entries. Reset empties
// the store at once (fill count); no clearing pass. The block holds in_ready_o
// low from acceptance until the item is stored or, for a final item, until
// the last result of a frame, if any, is transferred.
module particle_cull_group_depth_sort #(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  pcgds_pkg::pcgds_in_t                   in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output pcgds_pkg::pcgds_out_t                  out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pcgds_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [pcgds_pkg::CfgDataW-1:0]         cfg_data_i
);
  import pcgds_pkg::*;

  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned TW = KeyW + AW;
  localparam logic [CW-1:0] CntMax = CW'(MAX_PARTICLES);

  logic signed [DirW-1:0] dir_x_q, dir_y_q, dir_z_q;
  logic signed [PosW-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [15:0]            layer_q;

  pcgds_state_e state_q, state_d;
  pcgds_in_t    item_q;
  logic [1:0]   phase_q;
  logic signed [40:0]     prod_q;
  logic signed [AccW-1:0] acc_q;
  logic [CW-1:0] kept_q, scan_q, emit_q;
  logic          dropped_q;
  logic          rv_q, have_best_q, have_last_q;
  logic [TW-1:0] best_q, last_q;
  logic [AW-1:0] ridx_q;

  logic [KeyW-1:0]   key_mem [MAX_PARTICLES];
  logic [EntryW-1:0] pay_mem [MAX_PARTICLES];
  logic [KeyW-1:0]   key_rd_q;
  logic [EntryW-1:0] pay_rd_q;

  // one shared multiplier, operands chosen by phase
  logic signed [PosW:0]   diff;
  logic signed [DirW-1:0] dir_sel;
  always_comb begin
    diff    = {item_q.px[PosW-1], item_q.px} - {pos_x_q[PosW-1], pos_x_q};
    dir_sel = dir_x_q;
    case (phase_q)
      2'd1: begin
        diff    = {item_q.py[PosW-1], item_q.py} - {pos_y_q[PosW-1], pos_y_q};
        dir_sel = dir_y_q;
      end
      2'd2: begin
        diff    = {item_q.pz[PosW-1], item_q.pz} - {pos_z_q[PosW-1], pos_z_q};
        dir_sel = dir_z_q;
      end
      default: ;
    endcase
  end

  logic signed [AccW-1:0] sum;
  logic signed [AccW-1:0] sat;
  logic                   keep, store_en;
  logic [CW-1:0]          kept_new;
  logic [DepthW-1:0]      dep;
  assign sum      = acc_q + AccW'(prod_q);
  assign sat      = (sum > DepthMax) ? DepthMax : sum;
  assign dep      = sat[DepthW-1:0];
  assign keep     = !sum[AccW-1] && (item_q.layer == layer_q);
  assign store_en = (state_q == S_STORE) && keep && (kept_q != CntMax);
  assign kept_new = store_en ? kept_q + 1'b1 : kept_q;

  // sort key: texture pair, then depth with sign flipped, then arrival index
  logic [TW-1:0] cand;
  logic          take;
  assign cand = {key_rd_q, ridx_q};
  assign take = rv_q && (!have_last_q || cand > last_q) && (!have_best_q || cand < best_q);

  logic in_acc;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == S_EMIT);

  always_comb begin
    out_data_o = {pay_rd_q, dropped_q, 1'b0};
    out_data_o.is_last = (emit_q + 1'b1 == kept_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q <= '0;
      dir_y_q <= '0;
      dir_z_q <= 16'sd16384;
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      layer_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        RegDirX:  dir_x_q <= cfg_data_i[DirW-1:0];
        RegDirY:  dir_y_q <= cfg_data_i[DirW-1:0];
        RegDirZ:  dir_z_q <= cfg_data_i[DirW-1:0];
        RegPosX:  pos_x_q <= cfg_data_i;
        RegPosY:  pos_y_q <= cfg_data_i;
        RegPosZ:  pos_z_q <= cfg_data_i;
        RegLayer: layer_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MUL;
      S_MUL:   if (phase_q == 2'd2) state_d = S_STORE;
      S_STORE: begin
        if (!item_q.final_req || kept_new == '0) state_d = S_IDLE;
        else state_d = S_SCAN;
      end
      S_SCAN:  if (scan_q == kept_q && !rv_q) state_d = S_FETCH;
      S_FETCH: state_d = S_EMIT;
      S_EMIT: begin
        if (out_ready_i) state_d = (emit_q + 1'b1 == kept_q) ? S_IDLE : S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      kept_q      <= '0;
      dropped_q   <= 1'b0;
      scan_q      <= '0;
      emit_q      <= '0;
      rv_q        <= 1'b0;
      have_best_q <= 1'b0;
      have_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: phase_q <= '0;
        S_MUL:  phase_q <= phase_q + 1'b1;
        S_STORE: begin
          kept_q <= kept_new;
          if (keep && kept_q == CntMax) dropped_q <= 1'b1;
          if (item_q.final_req && kept_new == '0) dropped_q <= 1'b0;
          scan_q      <= '0;
          rv_q        <= 1'b0;
          emit_q      <= '0;
          have_best_q <= 1'b0;
          have_last_q <= 1'b0;
        end
        S_SCAN: begin
          if (scan_q != kept_q) begin
            scan_q <= scan_q + 1'b1;
            rv_q   <= 1'b1;
          end else begin
            rv_q <= 1'b0;
          end
          if (take) have_best_q <= 1'b1;
        end
        S_FETCH: ;
        S_EMIT: begin
          if (out_ready_i) begin
            have_last_q <= 1'b1;
            have_best_q <= 1'b0;
            scan_q      <= '0;
            emit_q      <= emit_q + 1'b1;
            if (emit_q + 1'b1 == kept_q) begin
              kept_q    <= '0;
              dropped_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    if (state_q == S_MUL) begin
      prod_q <= diff * dir_sel;
      acc_q  <= (phase_q == 2'd0) ? '0 : acc_q + AccW'(prod_q);
    end
    if (state_q == S_SCAN) ridx_q <= scan_q[AW-1:0];
    if (take) best_q <= cand;
    if (state_q == S_EMIT && out_ready_i) last_q <= best_q;
  end

  // entry stores
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      key_mem[kept_q[AW-1:0]] <= {item_q.tex_start, item_q.tex_end, ~dep[DepthW-1],
                                  dep[DepthW-2:0]};
      pay_mem[kept_q[AW-1:0]] <= {item_q.px, item_q.py, item_q.pz, item_q.pw,
                                  item_q.rgba, item_q.radius, item_q.fade,
                                  item_q.tex_start, item_q.tex_end, dep};
    end
    if (state_q == S_SCAN) key_rd_q <= key_mem[scan_q[AW-1:0]];
    if (state_q == S_FETCH) pay_rd_q <= pay_mem[best_q[AW-1:0]];
  end

endmodule
